### rtl/tkd_pkg.sv
// Shared widths, register indexes and the knot record of the trajectory knot decimator.
package tkd_pkg;

    localparam int POS_W   = 32;
    localparam int TIME_W  = 32;
    localparam int SPEED_W = 20;
    localparam int ACCEL_W = 16;
    localparam int HDG_W   = 16;
    localparam int DIST_W  = 32;
    localparam int THR_W   = 19;
    localparam int EPS_W   = 16;
    localparam int CFG_W   = 32;
    localparam int CFG_A_W = 2;
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 216;

    localparam logic [CFG_A_W-1:0] REG_STOP_THR  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_MIN_DIST  = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_MAX_HDG   = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_GEOM_EPS  = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0]  s;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [TIME_W-1:0]  tstamp;
        logic [SPEED_W-1:0] speed;
        logic [ACCEL_W-1:0] accel;
        logic [HDG_W-1:0]   heading;
    } knot_t;

    typedef struct packed {
        knot_t              knot;
        logic [TIME_W-1:0]  wait_us;
        logic               final_flag;
    } out_word_t;

endpackage

### rtl/trajectory_knot_decimator.sv
// Top level of the trajectory knot decimator: input capture, knot decisions and result queue.
//
// Usage: trajectory points enter on the s_axis channel, one word per point, with the
// first-point flag on s_axis_tuser and the last-point flag on s_axis_tlast. Spline knots
// leave on the m_axis channel; m_axis_tlast marks the final knot of a trajectory. A point
// yields zero, one or two knots. The user writes registers through cfg_we/cfg_addr/cfg_wdata
// only while idle, which the block does not enforce; a write takes effect at the next edge.
//
// Timing: the block takes one point at a time and accepts the next point only when the
// previous one has left its decision step. The distance unit is started, forms the
// coordinate differences, squares them in turn on the shared 32x32 multiplier, forms the
// sum and runs the bit-serial square root, one result bit per cycle. The distance is then
// handed over and the knot decision runs through ST_ACC, ST_DEC1 and ST_DEC2, after which
// the knots of the point appear on m_axis and the input is ready again.
//
// Knots wait in a two-word output queue. While the receiver stalls, the next point is
// still accepted and its distance computed; its decision step, and with it the input,
// holds until the queue is empty. Reset (rst_n low, asynchronous) empties the queue,
// drops any held knot, clears the trajectory state and loads the default register values.
module trajectory_knot_decimator (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [tkd_pkg::CFG_A_W-1:0]      cfg_addr,
    input  logic [tkd_pkg::CFG_W-1:0]        cfg_wdata,
    // Point input.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // pos_x[31:0], pos_y[63:32], time_us[95:64], speed[115:96], accel[131:116],
    // heading[147:132], zero fill[151:148]
    input  logic [tkd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // first_point[0]
    input  logic                             s_axis_tuser,
    input  logic                             s_axis_tlast,
    // Knot output.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // knot_s[31:0], knot_x[63:32], knot_y[95:64], knot_time[127:96], knot_speed[147:128],
    // knot_accel[163:148], knot_heading[179:164], knot_wait[211:180], zero fill[215:212]
    output logic [tkd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tlast
);
    import tkd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_DEC1 = 3'd3;
    localparam logic [2:0] ST_DEC2 = 3'd4;

    function automatic logic [DIST_W-1:0] sat_add32(input logic [DIST_W-1:0] a,
                                                    input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
    endfunction

    // Configuration registers.
    logic [THR_W-1:0]    thr_reg;
    logic [DIST_W-1:0]   min_dist_reg;
    logic [HDG_W-1:0]    max_hdg_reg;
    logic [EPS_W-1:0]    eps_reg;

    // Captured point.
    knot_t               pt_reg;
    logic                pt_first_reg, pt_last_reg;

    // Trajectory state.
    logic [POS_W-1:0]    prev_x_reg, prev_y_reg;
    logic [TIME_W-1:0]   prev_time_reg;
    logic [SPEED_W-1:0]  prev_speed_reg;
    logic [DIST_W-1:0]   pending_reg, pending_next;
    logic [DIST_W-1:0]   path_reg, path_next;
    logic [HDG_W-1:0]    last_hdg_reg, last_hdg_next;
    knot_t               held_reg, held_next;
    logic [TIME_W-1:0]   held_wait_reg, held_wait_next;
    logic                held_valid_reg, held_valid_next;

    // Values prepared in ST_ACC, just before the decision.
    logic [DIST_W-1:0]   pend_sum_reg;
    logic [TIME_W-1:0]   dt_reg;
    logic                stopped_reg, prev_fast_reg, turn_reg;

    // Control and result queue.
    logic [2:0]          state_reg, state_next;
    logic                start_reg;
    logic [1:0]          out_cnt_reg, out_cnt_next;
    out_word_t           q_data_reg [2];
    logic [1:0]          q_cnt_reg, q_cnt_next;
    logic                q_head_reg, q_head_next;
    logic [1:0]          q_wr_en;
    out_word_t           q_wr_data [2];

    logic                dist_done;
    logic [DIST_W-1:0]   step_dist;
    logic                in_fire, out_fire;

    // Decision helpers.
    logic [SPEED_W-1:0]  speed_mag;
    logic [HDG_W-1:0]    hdg_diff, hdg_abs;
    logic [DIST_W-1:0]   pend1, path_add;
    logic                addk;
    knot_t               kn;
    knot_t               h;
    logic [TIME_W-1:0]   hw;
    logic                hv;
    logic [1:0]          cnt;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    tkd_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .pos_x   (pt_reg.x),
        .pos_y   (pt_reg.y),
        .prev_x  (prev_x_reg),
        .prev_y  (prev_y_reg),
        .done    (dist_done),
        .dist_mm (step_dist)
    );

    // Quantities that depend only on the point and the state before the decision.
    assign speed_mag = pt_reg.speed[SPEED_W-1] ? (~pt_reg.speed + 1'b1) : pt_reg.speed;
    assign hdg_diff  = pt_reg.heading - last_hdg_reg;
    // Wrapped absolute difference: anything past a half turn is measured the other way.
    assign hdg_abs   = (hdg_diff > {1'b1, {(HDG_W-1){1'b0}}}) ? (~hdg_diff + 1'b1) : hdg_diff;

    always_comb
    begin
        state_next      = state_reg;
        pending_next    = pending_reg;
        path_next       = path_reg;
        last_hdg_next   = last_hdg_reg;
        held_next       = held_reg;
        held_wait_next  = held_wait_reg;
        held_valid_next = held_valid_reg;
        out_cnt_next    = out_cnt_reg;
        q_cnt_next      = q_cnt_reg;
        q_head_next     = q_head_reg;
        q_wr_en         = '0;
        q_wr_data[0]    = '0;
        q_wr_data[1]    = '0;
        pend1           = '0;
        path_add        = '0;
        addk            = 1'b0;
        kn              = pt_reg;
        h               = held_reg;
        hw              = held_wait_reg;
        hv              = held_valid_reg;
        cnt             = out_cnt_reg;

        if (out_fire)
        begin
            q_cnt_next  = q_cnt_reg - 1'b1;
            q_head_next = (q_cnt_reg == 2'd1) ? 1'b0 : ~q_head_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire) state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (dist_done) state_next = ST_ACC;
            end
            ST_ACC:
            begin
                // The decision may write two knots, so it waits for an empty queue.
                if (q_cnt_reg == 2'd0) state_next = ST_DEC1;
            end
            ST_DEC1:
            begin
                state_next   = ST_DEC2;
                out_cnt_next = 2'd0;
                // A stopped point counts the last step only when the previous point was moving.
                pend1 = (stopped_reg && !prev_fast_reg) ? pending_reg : pend_sum_reg;
                if (stopped_reg)
                    addk = pend1 > DIST_W'(eps_reg);
                else
                    addk = (pend1 >= min_dist_reg) ||
                           (turn_reg && (pend1 >= DIST_W'(eps_reg)));
                path_add = sat_add32(path_reg, pend1);
                if (stopped_reg)
                begin
                    kn.speed = '0;
                    kn.accel = '0;
                end
                if (pt_first_reg)
                begin
                    // Restart: the held knot is dropped without being sent.
                    pending_next    = '0;
                    path_next       = '0;
                    held_next       = pt_reg;
                    held_wait_next  = '0;
                    held_valid_next = 1'b1;
                    last_hdg_next   = pt_reg.heading;
                end
                else
                begin
                    pending_next = pend1;
                    if (addk)
                    begin
                        path_next = path_add;
                        if (held_valid_reg)
                        begin
                            q_wr_en[0]   = 1'b1;
                            q_wr_data[0] = '{knot: held_reg, wait_us: held_wait_reg,
                                             final_flag: 1'b0};
                            out_cnt_next = 2'd1;
                        end
                        held_next       = kn;
                        held_next.s     = path_add;
                        held_wait_next  = '0;
                        held_valid_next = 1'b1;
                        pending_next    = '0;
                        last_hdg_next   = pt_reg.heading;
                    end
                    if (stopped_reg && (addk || held_valid_reg))
                    begin
                        held_wait_next  = sat_add32(addk ? '0 : held_wait_reg, dt_reg);
                        held_next.speed = '0;
                        held_next.accel = '0;
                    end
                end
            end
            ST_DEC2:
            begin
                state_next  = ST_IDLE;
                q_head_next = 1'b0;
                if (pt_last_reg)
                begin
                    if (pending_reg > DIST_W'(eps_reg))
                    begin
                        path_add  = sat_add32(path_reg, pending_reg);
                        path_next = path_add;
                        if (hv)
                        begin
                            q_wr_en[cnt[0]]   = 1'b1;
                            q_wr_data[cnt[0]] = '{knot: held_reg, wait_us: held_wait_reg,
                                                  final_flag: 1'b0};
                            cnt = cnt + 1'b1;
                        end
                        h             = pt_reg;
                        h.s           = path_add;
                        hw            = '0;
                        hv            = 1'b1;
                        pending_next  = '0;
                        last_hdg_next = pt_reg.heading;
                    end
                    // Flush the held knot as the final one, if there is room for it.
                    if (hv && (cnt < 2'd2))
                    begin
                        q_wr_en[cnt[0]]   = 1'b1;
                        q_wr_data[cnt[0]] = '{knot: h, wait_us: hw, final_flag: 1'b1};
                        cnt = cnt + 1'b1;
                        hv  = 1'b0;
                    end
                    held_next       = h;
                    held_wait_next  = hw;
                    held_valid_next = hv;
                end
                q_cnt_next = cnt;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THR_W'(10);
            min_dist_reg   <= DIST_W'(1000);
            max_hdg_reg    <= HDG_W'(1043);
            eps_reg        <= EPS_W'(1);
            state_reg      <= ST_IDLE;
            start_reg      <= 1'b0;
            out_cnt_reg    <= '0;
            q_cnt_reg      <= '0;
            q_head_reg     <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_time_reg  <= '0;
            prev_speed_reg <= '0;
            pending_reg    <= '0;
            path_reg       <= '0;
            last_hdg_reg   <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_STOP_THR: thr_reg      <= cfg_wdata[THR_W-1:0];
                    REG_MIN_DIST: min_dist_reg <= cfg_wdata[DIST_W-1:0];
                    REG_MAX_HDG:  max_hdg_reg  <= cfg_wdata[HDG_W-1:0];
                    REG_GEOM_EPS: eps_reg      <= cfg_wdata[EPS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            state_reg      <= state_next;
            start_reg      <= in_fire;
            out_cnt_reg    <= out_cnt_next;
            q_cnt_reg      <= q_cnt_next;
            q_head_reg     <= q_head_next;
            pending_reg    <= pending_next;
            path_reg       <= path_next;
            last_hdg_reg   <= last_hdg_next;
            held_valid_reg <= held_valid_next;
            if (state_reg == ST_DEC2)
            begin
                prev_x_reg     <= pt_reg.x;
                prev_y_reg     <= pt_reg.y;
                prev_time_reg  <= pt_reg.tstamp;
                prev_speed_reg <= pt_reg.speed;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pt_reg.s       <= '0;
            pt_reg.x       <= s_axis_tdata[31:0];
            pt_reg.y       <= s_axis_tdata[63:32];
            pt_reg.tstamp  <= s_axis_tdata[95:64];
            pt_reg.speed   <= s_axis_tdata[115:96];
            pt_reg.accel   <= s_axis_tdata[131:116];
            pt_reg.heading <= s_axis_tdata[147:132];
            pt_first_reg   <= s_axis_tuser;
            pt_last_reg    <= s_axis_tlast;
        end
        if (state_reg == ST_ACC)
        begin
            pend_sum_reg  <= sat_add32(pending_reg, step_dist);
            dt_reg        <= pt_reg.tstamp - prev_time_reg;
            stopped_reg   <= speed_mag < SPEED_W'(thr_reg);
            // Previous speed is signed; only a positive value can exceed the threshold.
            prev_fast_reg <= !prev_speed_reg[SPEED_W-1] &&
                             (prev_speed_reg[SPEED_W-2:0] > thr_reg);
            turn_reg      <= hdg_abs >= max_hdg_reg;
        end
        held_reg      <= held_next;
        held_wait_reg <= held_wait_next;
        if (q_wr_en[0]) q_data_reg[0] <= q_wr_data[0];
        if (q_wr_en[1]) q_data_reg[1] <= q_wr_data[1];
    end

    out_word_t head_word;
    assign head_word     = q_data_reg[q_head_reg];
    assign m_axis_tvalid = (q_cnt_reg != 2'd0);
    assign m_axis_tlast  = head_word.final_flag;
    assign m_axis_tdata  = {4'b0000, head_word.wait_us, head_word.knot.heading,
                            head_word.knot.accel, head_word.knot.speed,
                            head_word.knot.tstamp, head_word.knot.y,
                            head_word.knot.x, head_word.knot.s};

    // The decision only runs into an empty queue, so no knot is overwritten.
    a_dec_queue_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEC1 || state_reg == ST_DEC2) |-> (q_cnt_reg == 2'd0))
        else $error("knot decision started with words still queued");

    // A finished distance must find the controller waiting for it.
    a_dist_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        dist_done |-> (state_reg == ST_RUN))
        else $error("distance result arrived outside the run state");

    // The held knot is released only by the flush of a last point.
    a_held_drop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(held_valid_reg) |-> ($past(state_reg) == ST_DEC2 && $past(pt_last_reg)))
        else $error("held knot dropped without a last point");

    // Every word taken from the queue lowers its count by exactly one.
    a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |=> (q_cnt_reg == $past(q_cnt_reg) - 2'd1))
        else $error("queue count did not follow a taken word");

endmodule

### rtl/tkd_dist.sv
// Planar distance unit: squared difference through one shared multiplier, then a bit-serial root.
module tkd_dist (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tkd_pkg::POS_W-1:0]  pos_x,
    input  logic [tkd_pkg::POS_W-1:0]  pos_y,
    input  logic [tkd_pkg::POS_W-1:0]  prev_x,
    input  logic [tkd_pkg::POS_W-1:0]  prev_y,
    output logic                       done,
    output logic [tkd_pkg::DIST_W-1:0] dist_mm
);
    import tkd_pkg::*;

    localparam int SQ_W  = 2 * POS_W;
    localparam int REM_W = DIST_W + 2;
    localparam int CNT_W = $clog2(DIST_W);

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_DIFF = 3'd1;
    localparam logic [2:0] D_SQX  = 3'd2;
    localparam logic [2:0] D_SQY  = 3'd3;
    localparam logic [2:0] D_SUM  = 3'd4;
    localparam logic [2:0] D_ROOT = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [POS_W-1:0]  ux_reg, uy_reg;
    logic [SQ_W-1:0]   prod_reg, acc_reg;
    logic [SQ_W-1:0]   n_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DIST_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;

    logic [POS_W:0]    dx, dy;
    logic [POS_W:0]    ax, ay;
    logic [POS_W-1:0]  mul_a;
    logic [SQ_W-1:0]   mul_p;
    logic [SQ_W:0]     sq_sum;
    logic [REM_W+1:0]  r2, trial;
    logic              ge;

    assign dx    = {pos_x[POS_W-1], pos_x} - {prev_x[POS_W-1], prev_x};
    assign dy    = {pos_y[POS_W-1], pos_y} - {prev_y[POS_W-1], prev_y};
    assign ax    = dx[POS_W] ? (~dx + 1'b1) : dx;
    assign ay    = dy[POS_W] ? (~dy + 1'b1) : dy;
    assign mul_a = (state_reg == D_SQX) ? ux_reg : uy_reg;
    assign mul_p = mul_a * mul_a;
    assign sq_sum = {1'b0, acc_reg} + {1'b0, prod_reg};

    // One root bit per cycle from the top two bits of the radicand.
    assign r2    = {rem_reg, n_reg[SQ_W-1:SQ_W-2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = (r2 >= trial);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE: if (start) state_next = D_DIFF;
            D_DIFF: state_next = D_SQX;
            D_SQX:  state_next = D_SQY;
            D_SQY:  state_next = D_SUM;
            D_SUM:  state_next = D_ROOT;
            D_ROOT: if (cnt_reg == CNT_W'(DIST_W - 1)) state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == D_ROOT) && (cnt_reg == CNT_W'(DIST_W - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_DIFF:
            begin
                ux_reg <= ax[POS_W-1:0];
                uy_reg <= ay[POS_W-1:0];
            end
            D_SQX:
            begin
                prod_reg <= mul_p;
            end
            D_SQY:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            D_SUM:
            begin
                // An overflowing sum clamps to all ones, whose root is the saturated distance.
                n_reg    <= sq_sum[SQ_W] ? {SQ_W{1'b1}} : sq_sum[SQ_W-1:0];
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            D_ROOT:
            begin
                n_reg    <= {n_reg[SQ_W-3:0], 2'b00};
                rem_reg  <= ge ? REM_W'(r2 - trial) : REM_W'(r2);
                root_reg <= {root_reg[DIST_W-2:0], ge};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign done    = done_reg;
    assign dist_mm = root_reg;

endmodule
